/* design/segcp_pkg.sv */
// shared types, widths and helpers for the segment closest-point core
// no dependencies; every other design file imports this package
`default_nettype none

package segcp_pkg;

	// coordinate format: signed q16.16
	localparam int COORD_W = 32;
	localparam int FRAC_W  = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int DEN_W   = 2 * COORD_W + 2;
	localparam int NUM_W   = DEN_W + 1;
	localparam int QUO_W   = COORD_W;

	// stream payload layout, field index from the lowest bits up
	localparam int IN_FIELDS = 8;
	localparam int IN_W      = IN_FIELDS * COORD_W;
	localparam int OUT_W     = 4 * COORD_W;
	localparam int F_PX = 0;
	localparam int F_PZ = 1;
	localparam int F_SX = 2;
	localparam int F_SY = 3;
	localparam int F_SZ = 4;
	localparam int F_EX = 5;
	localparam int F_EY = 6;
	localparam int F_EZ = 7;

	localparam int DIV_STEPS = QUO_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	typedef enum logic [1:0] {
		REG_BEFORE = 2'd0,
		REG_END    = 2'd1,
		REG_INSIDE = 2'd2
	} region_t;

	localparam coord_t FRAC_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t FRAC_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// segment start and direction, carried down the whole pipeline
	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t sz;
		diff_t  dx;
		diff_t  dy;
		diff_t  dz;
	} seg_t;

	// front end result: |num| and den of the projection ratio
	typedef struct packed {
		seg_t               seg;
		logic               neg;
		logic               den_zero;
		logic [DEN_W-1:0]   mag;
		logic [DEN_W-1:0]   den;
	} ratio_t;

	// one divider stage
	typedef struct packed {
		seg_t               seg;
		logic               neg;
		logic               den_zero;
		logic               sat;
		logic               at_end;
		logic [DEN_W-1:0]   den;
		logic [DEN_W-1:0]   rem;
		logic [QUO_W-1:0]   bits;
	} div_st_t;

	// divider result
	typedef struct packed {
		seg_t               seg;
		logic               neg;
		logic               den_zero;
		logic               sat;
		logic               at_end;
		logic               rem_nz;
		logic [QUO_W-1:0]   quo;
	} quot_t;

	typedef struct packed {
		coord_t  near_x;
		coord_t  near_y;
		coord_t  near_z;
		coord_t  fraction;
		region_t region;
	} res_t;

	function automatic diff_t widen(input coord_t c);
		return {c[COORD_W-1], c};
	endfunction

	// one restoring step: shift in the next dividend bit, subtract if it fits
	function automatic div_st_t div_step(input div_st_t a);
		logic [DEN_W:0] t;
		logic           qb;
		div_st_t        r;
		r  = a;
		t  = {a.rem, a.bits[QUO_W-1]};
		qb = 1'b0;
		if (t >= {1'b0, a.den}) begin
			t  = t - {1'b0, a.den};
			qb = 1'b1;
		end
		r.rem  = t[DEN_W-1:0];
		r.bits = {a.bits[QUO_W-2:0], qb};
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/segment_closest_point_xz_core.sv */
// closest point on a 3d segment, projected in the xz plane, signed q16.16.
// takes one item per clock while s_tready is high and returns one result
// item for each, in order. the result passes through 40 register stages
// after the item is taken (4 front-end stages for differences, products
// and the ratio terms, 32 divider stages producing one quotient bit each,
// 3 back-end stages, 1 output register).
// the 32-stage restoring divider sets that depth. a skid slot behind the
// output register keeps s_tready a registered signal: when the consumer
// holds m_tready low and a further result arrives, it waits in the skid slot,
// the whole pipeline freezes and nothing is dropped or repeated. fraction is floor(num*65536/den),
// saturated; region 0 gives start, region 1 gives end, region 2 gives
// start + fraction*(end - start). a segment with no horizontal extent
// gives fraction 0, region 2 and the start point.
// depends on segcp_pkg, segcp_front, segcp_div, segcp_back, segcp_obuf
`default_nettype none

module segment_closest_point_xz_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// input item
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// point_x, point_z, start_x, start_y, start_z, end_x, end_y, end_z
	input  logic [segcp_pkg::IN_W-1:0]  s_tdata,
	// result item
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// near_x, near_y, near_z, fraction
	output logic [segcp_pkg::OUT_W-1:0] m_tdata,
	// region
	output logic [1:0]                  m_tuser
);
	import segcp_pkg::*;

	// global pipeline advance, taken from the registered skid state
	logic   en;
	logic   front_v, div_v, back_v;
	ratio_t front_d;
	quot_t  div_d;
	res_t   back_d, out_res;

	assign s_tready = en;

	segcp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.out_valid(front_v),
		.out_data (front_d)
	);

	segcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (front_v),
		.in_data  (front_d),
		.out_valid(div_v),
		.out_data (div_d)
	);

	segcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (div_v),
		.in_data  (div_d),
		.out_valid(back_v),
		.out_data (back_d)
	);

	// output register plus skid slot
	segcp_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (back_v),
		.in_data  (back_d),
		.room     (en),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_res)
	);

	assign m_tdata = {out_res.fraction, out_res.near_z, out_res.near_y, out_res.near_x};
	assign m_tuser = out_res.region;

`ifndef SYNTHESIS
	// region and fraction come from separate paths and must agree
	ap_before_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_res.region == REG_BEFORE |-> out_res.fraction[COORD_W-1])
		else $error("region before start with non-negative fraction");

	ap_end_ge_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_res.region == REG_END |->
		!out_res.fraction[COORD_W-1] && (out_res.fraction[COORD_W-2:FRAC_W] != '0))
		else $error("region at end with fraction below one");

	ap_inside_unit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_res.region == REG_INSIDE |->
		!out_res.fraction[COORD_W-1] && (out_res.fraction[COORD_W-2:FRAC_W] == '0))
		else $error("interior region with fraction outside [0,1)");
`endif

endmodule

`default_nettype wire

/* design/segcp_front.sv */
// front end: differences, products and the exact ratio terms of t
// depends on segcp_pkg
`default_nettype none

module segcp_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [segcp_pkg::IN_W-1:0] in_data,
	output logic                      out_valid,
	output segcp_pkg::ratio_t         out_data
);
	import segcp_pkg::*;

	coord_t px, pz, sx, sy, sz, ex, ey, ez;
	seg_t   seg_c;

	seg_t   seg_s1, seg_s2, seg_s3;
	diff_t  ox_s1, oz_s1;
	logic signed [PROD_W-1:0] dxx_s2, dzz_s2, pxd_s2, pzd_s2;
	logic [DEN_W-1:0]         den_s3;
	logic signed [NUM_W-1:0]  num_s3;
	logic [NUM_W-1:0]         num_abs;
	logic [3:0]               v_s;

	assign px = in_data[F_PX*COORD_W +: COORD_W];
	assign pz = in_data[F_PZ*COORD_W +: COORD_W];
	assign sx = in_data[F_SX*COORD_W +: COORD_W];
	assign sy = in_data[F_SY*COORD_W +: COORD_W];
	assign sz = in_data[F_SZ*COORD_W +: COORD_W];
	assign ex = in_data[F_EX*COORD_W +: COORD_W];
	assign ey = in_data[F_EY*COORD_W +: COORD_W];
	assign ez = in_data[F_EZ*COORD_W +: COORD_W];

	always_comb begin
		seg_c.sx = sx;
		seg_c.sy = sy;
		seg_c.sz = sz;
		seg_c.dx = widen(ex) - widen(sx);
		seg_c.dy = widen(ey) - widen(sy);
		seg_c.dz = widen(ez) - widen(sz);
	end

	assign num_abs = num_s3[NUM_W-1] ? -num_s3 : num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: direction and point offset
			seg_s1 <= seg_c;
			ox_s1  <= widen(px) - widen(sx);
			oz_s1  <= widen(pz) - widen(sz);
			// s2: four signed products
			seg_s2 <= seg_s1;
			dxx_s2 <= seg_s1.dx * seg_s1.dx;
			dzz_s2 <= seg_s1.dz * seg_s1.dz;
			pxd_s2 <= ox_s1 * seg_s1.dx;
			pzd_s2 <= oz_s1 * seg_s1.dz;
			// s3: dot product and squared length
			seg_s3 <= seg_s2;
			den_s3 <= $unsigned(dxx_s2) + $unsigned(dzz_s2);
			num_s3 <= {pxd_s2[PROD_W-1], pxd_s2} + {pzd_s2[PROD_W-1], pzd_s2};
			// s4: sign and magnitude
			out_data.seg      <= seg_s3;
			out_data.neg      <= num_s3[NUM_W-1];
			out_data.den_zero <= (den_s3 == '0);
			out_data.mag      <= num_abs[DEN_W-1:0];
			out_data.den      <= den_s3;
		end
	end

	assign out_valid = v_s[3];

endmodule

`default_nettype wire

/* design/segcp_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on segcp_pkg
`default_nettype none

module segcp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  segcp_pkg::ratio_t in_data,
	output logic              out_valid,
	output segcp_pkg::quot_t  out_data
);
	import segcp_pkg::*;

	div_st_t              init;
	div_st_t              st_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] v_s;

	// dividend is |num| << 16; its top part seeds the remainder
	always_comb begin
		init.seg      = in_data.seg;
		init.neg      = in_data.neg;
		init.den_zero = in_data.den_zero;
		init.den      = in_data.den;
		init.sat      = in_data.mag[DEN_W-1:FRAC_W] >= in_data.den;
		init.at_end   = in_data.mag >= in_data.den;
		init.rem      = {{FRAC_W{1'b0}}, in_data.mag[DEN_W-1:FRAC_W]};
		init.bits     = {in_data.mag[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_STEPS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= div_step(init);
			for (int k = 1; k < DIV_STEPS; k++) begin
				st_s[k] <= div_step(st_s[k-1]);
			end
		end
	end

	always_comb begin
		out_data.seg      = st_s[DIV_STEPS-1].seg;
		out_data.neg      = st_s[DIV_STEPS-1].neg;
		out_data.den_zero = st_s[DIV_STEPS-1].den_zero;
		out_data.sat      = st_s[DIV_STEPS-1].sat;
		out_data.at_end   = st_s[DIV_STEPS-1].at_end;
		out_data.rem_nz   = |st_s[DIV_STEPS-1].rem;
		out_data.quo      = st_s[DIV_STEPS-1].bits;
	end

	assign out_valid = v_s[DIV_STEPS-1];

endmodule

`default_nettype wire

/* design/segcp_back.sv */
// back end: fraction rounding and saturation, region, interpolated point
// depends on segcp_pkg
`default_nettype none

module segcp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  segcp_pkg::quot_t in_data,
	output logic             out_valid,
	output segcp_pkg::res_t  out_data
);
	import segcp_pkg::*;

	logic [QUO_W-1:0] q;
	logic             neg_big;
	coord_t           frac_c;
	region_t          region_c;

	logic signed [FRAC_W+DIFF_W:0] prod_x, prod_y, prod_z;

	seg_t    seg_s1, seg_s2;
	coord_t  frac_s1, frac_s2;
	region_t region_s1, region_s2;
	coord_t  offx_s2, offy_s2, offz_s2;
	logic [2:0] v_s;

	function automatic coord_t pick(input region_t r, input coord_t s, input diff_t d,
			input coord_t off);
		coord_t add;
		case (r)
			REG_BEFORE: add = '0;
			REG_END:    add = d[COORD_W-1:0];
			default:    add = off;
		endcase
		return s + add;
	endfunction

	assign q = in_data.quo;
	// ceil of a negative quotient runs past the most negative value
	assign neg_big = q[QUO_W-1] && ((|q[QUO_W-2:0]) || in_data.rem_nz);

	always_comb begin
		if (in_data.den_zero) begin
			frac_c = '0;
		end else if (in_data.sat) begin
			frac_c = in_data.neg ? FRAC_MIN : FRAC_MAX;
		end else if (in_data.neg) begin
			frac_c = neg_big ? FRAC_MIN : (~q + QUO_W'(!in_data.rem_nz));
		end else begin
			frac_c = q[QUO_W-1] ? FRAC_MAX : q;
		end

		if (in_data.den_zero) begin
			region_c = REG_INSIDE;
		end else if (in_data.neg) begin
			region_c = REG_BEFORE;
		end else if (in_data.at_end) begin
			region_c = REG_END;
		end else begin
			region_c = REG_INSIDE;
		end
	end

	// interior fraction is below one, so its low 16 bits carry all of it
	assign prod_x = $signed({1'b0, frac_s1[FRAC_W-1:0]}) * seg_s1.dx;
	assign prod_y = $signed({1'b0, frac_s1[FRAC_W-1:0]}) * seg_s1.dy;
	assign prod_z = $signed({1'b0, frac_s1[FRAC_W-1:0]}) * seg_s1.dz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1    <= in_data.seg;
			frac_s1   <= frac_c;
			region_s1 <= region_c;

			seg_s2    <= seg_s1;
			frac_s2   <= frac_s1;
			region_s2 <= region_s1;
			offx_s2   <= prod_x[COORD_W+FRAC_W-1:FRAC_W];
			offy_s2   <= prod_y[COORD_W+FRAC_W-1:FRAC_W];
			offz_s2   <= prod_z[COORD_W+FRAC_W-1:FRAC_W];

			out_data.near_x   <= pick(region_s2, seg_s2.sx, seg_s2.dx, offx_s2);
			out_data.near_y   <= pick(region_s2, seg_s2.sy, seg_s2.dy, offy_s2);
			out_data.near_z   <= pick(region_s2, seg_s2.sz, seg_s2.dz, offz_s2);
			out_data.fraction <= frac_s2;
			out_data.region   <= region_s2;
		end
	end

	assign out_valid = v_s[2];

endmodule

`default_nettype wire

/* design/segcp_obuf.sv */
// output register with a skid slot, so the pipeline stall is registered
// depends on segcp_pkg
`default_nettype none

module segcp_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  segcp_pkg::res_t in_data,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output segcp_pkg::res_t out_data
);
	import segcp_pkg::*;

	logic out_v_q, skid_v_q;
	res_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || out_ready) begin
			out_v_q <= in_valid;
		end else if (in_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) begin
				out_data <= skid_q;
			end
		end else if (!out_v_q || out_ready) begin
			if (in_valid) begin
				out_data <= in_data;
			end
		end else if (in_valid) begin
			skid_q <= in_data;
		end
	end

	assign room      = !skid_v_q;
	assign out_valid = out_v_q;

endmodule

`default_nettype wire

/* tb/segment_closest_point_xz_core_test.sv */
// self-checking bench for segment_closest_point_xz_core: a directed table, then random queries
// every accepted item is predicted in place, or taken from the table, and compared with the result item, field by field
// depends on segcp_pkg and segment_closest_point_xz_core
`default_nettype none

module segment_closest_point_xz_core_test;

	import segcp_pkg::*;

	localparam int     RANDOM_ITEMS = 1400;
	localparam int     DRAIN_EVERY  = 400;
	// 40 pipeline stages plus the skid slot, with margin
	localparam int     SETTLE       = 60;
	localparam int     CYCLE_LIMIT  = 400000;
	localparam coord_t ONE          = 32'sh0001_0000;

	// packed so that px sits in the lowest bits, matching s_tdata
	typedef struct packed {
		coord_t ez;
		coord_t ey;
		coord_t ex;
		coord_t sz;
		coord_t sy;
		coord_t sx;
		coord_t pz;
		coord_t px;
	} query_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;
	logic [1:0]         m_tuser;

	res_t   pending_res[$];
	query_t dir_query[$];
	bit     dir_known[$];
	res_t   dir_want[$];

	int     cycles       = 0;
	int     errors       = 0;
	int     sent         = 0;
	int     checked      = 0;
	int     burst_left   = 0;
	int     region_seen[3];

	// receiver stall pattern
	int     stall_mode   = 0;
	int     mode_left    = 0;
	int     hold_left    = 0;

	segment_closest_point_xz_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// exact projection in 128-bit integers, no intermediate rounding
	function automatic res_t closest_point(input query_t q);
		logic signed [127:0] sx, sy, sz, ex, ey, ez, px, pz;
		logic signed [127:0] dx, dy, dz, ox, oz, num, den, frac;
		logic signed [127:0] lim_hi, lim_lo;
		logic [127:0]        mag, den_u, quo, rem;
		res_t                r;
		sx = q.sx;  sy = q.sy;  sz = q.sz;
		ex = q.ex;  ey = q.ey;  ez = q.ez;
		px = q.px;  pz = q.pz;
		lim_hi = FRAC_MAX;
		lim_lo = FRAC_MIN;
		dx  = ex - sx;
		dy  = ey - sy;
		dz  = ez - sz;
		ox  = px - sx;
		oz  = pz - sz;
		num = ox * dx + oz * dz;
		den = dx * dx + dz * dz;
		frac = 0;
		r.region = REG_INSIDE;
		if (den != 0) begin
			if (num < 0)
				r.region = REG_BEFORE;
			else if (num >= den)
				r.region = REG_END;
			// floor of num*2^16/den: magnitude division, round away on the negative side
			mag   = (num < 0) ? -num : num;
			den_u = den;
			quo   = (mag << 16) / den_u;
			rem   = (mag << 16) % den_u;
			if (num < 0) begin
				if (rem != 0)
					quo = quo + 1;
				frac = -$signed(quo);
			end else begin
				frac = $signed(quo);
			end
			if (frac > lim_hi)
				frac = lim_hi;
			if (frac < lim_lo)
				frac = lim_lo;
		end
		r.fraction = frac[31:0];
		case (r.region)
			REG_BEFORE: begin
				r.near_x = q.sx;
				r.near_y = q.sy;
				r.near_z = q.sz;
			end
			REG_END: begin
				r.near_x = q.ex;
				r.near_y = q.ey;
				r.near_z = q.ez;
			end
			default: begin
				// frac is in [0, 1) here, so the arithmetic shift is the floor
				r.near_x = 32'(sx + ((frac * dx) >>> 16));
				r.near_y = 32'(sy + ((frac * dy) >>> 16));
				r.near_z = 32'(sz + ((frac * dz) >>> 16));
			end
		endcase
		return r;
	endfunction

	function automatic query_t qry(input coord_t px, pz, sx, sy, sz, ex, ey, ez);
		query_t q;
		q.px = px;  q.pz = pz;
		q.sx = sx;  q.sy = sy;  q.sz = sz;
		q.ex = ex;  q.ey = ey;  q.ez = ez;
		return q;
	endfunction

	function automatic res_t rslt(input coord_t nx, ny, nz, fr, input region_t rg);
		res_t r;
		r.near_x   = nx;
		r.near_y   = ny;
		r.near_z   = nz;
		r.fraction = fr;
		r.region   = rg;
		return r;
	endfunction

	task automatic add_row(input query_t q, input bit known, input res_t want);
		dir_query.push_back(q);
		dir_known.push_back(known);
		dir_want.push_back(want);
	endtask

	// mixed scales: full range, a few lsbs, extremes, shifted, whole units
	function automatic coord_t any_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return coord_t'(int'($urandom_range(0, 64)) - 32);
			2: begin
				case ($urandom_range(0, 4))
					0: return FRAC_MIN;
					1: return FRAC_MAX;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			3: return $signed($urandom) >>> $urandom_range(1, 28);
			default: return coord_t'((int'($urandom_range(0, 200)) - 100) * ONE);
		endcase
	endfunction

	// magnitude at most 2^26, so sums of a few stay in range
	function automatic coord_t mid_coord();
		return $signed($urandom) >>> $urandom_range(5, 14);
	endfunction

	function automatic query_t random_query();
		query_t q;
		longint k;
		q = qry(any_coord(), any_coord(), any_coord(), any_coord(),
			any_coord(), any_coord(), any_coord(), any_coord());
		case ($urandom_range(0, 9))
			0, 1: begin
				q = {$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom};
			end
			2, 3, 4, 5: begin
				// ordinary geometry: point placed around the segment, t from -0.5 to 1.5
				q = qry(0, 0, mid_coord(), mid_coord(), mid_coord(),
					mid_coord(), mid_coord(), mid_coord());
				k = longint'($urandom_range(0, 16)) - 4;
				q.px = coord_t'(q.sx + ((longint'(q.ex) - q.sx) * k) / 8 + (mid_coord() >>> 6));
				k = longint'($urandom_range(0, 16)) - 4;
				q.pz = coord_t'(q.sz + ((longint'(q.ez) - q.sz) * k) / 8 + (mid_coord() >>> 6));
			end
			6: begin
				// no horizontal extent
				q.ex = q.sx;
				q.ez = q.sz;
			end
			7: begin
				// query exactly on an endpoint
				if ($urandom_range(0, 1)) begin
					q.px = q.ex;
					q.pz = q.ez;
				end else begin
					q.px = q.sx;
					q.pz = q.sz;
				end
			end
			9: begin
				// a few lsbs of length: rounding and saturation
				q.ex = q.sx + coord_t'(int'($urandom_range(0, 4)) - 2);
				q.ez = q.sz + coord_t'(int'($urandom_range(0, 4)) - 2);
			end
			default: ;
		endcase
		return q;
	endfunction

	// offer one item, wait for the handshake, then maybe idle for a while
	task automatic send_query(input query_t q, input bit known, input res_t want);
		int gap;
		s_tdata  <= q;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_res.push_back(known ? want : closest_point(q));
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// gaps up to longer than the pipeline so that they land on every stage
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap)
				@(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(0, 20);
		end
	endtask

	// hold the sender off until the pipeline has emptied
	task automatic drain_results();
		if (pending_res.size() != 0) begin
			s_tvalid <= 1'b0;
			while (pending_res.size() != 0)
				@(posedge clk);
		end
	endtask

	// receiver: the stall pattern is redrawn whenever its mode counter runs out, then result checking
	always @(posedge clk) begin : rx_side
		res_t got;
		res_t want;
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left  <= $urandom_range(50, 400);
		end else begin
			mode_left  <= mode_left - 1;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (cycles % 4 == 0);
			default: begin
				// long stretches high or low
				if (hold_left == 0) begin
					m_tready  <= ~m_tready;
					hold_left <= $urandom_range(1, 20);
				end else begin
					hold_left <= hold_left - 1;
				end
			end
		endcase

		if (arst_n && m_tvalid && m_tready) begin
			got.near_x   = m_tdata[31:0];
			got.near_y   = m_tdata[63:32];
			got.near_z   = m_tdata[95:64];
			got.fraction = m_tdata[127:96];
			got.region   = region_t'(m_tuser);
			if (pending_res.size() == 0) begin
				$error("result item with no item waiting for it");
				errors++;
			end else begin
				want = pending_res.pop_front();
				checked++;
				if (got.region < 3)
					region_seen[got.region]++;
				if (got.near_x !== want.near_x) begin
					$error("near_x: expected %h, got %h", want.near_x, got.near_x);
					errors++;
				end
				if (got.near_y !== want.near_y) begin
					$error("near_y: expected %h, got %h", want.near_y, got.near_y);
					errors++;
				end
				if (got.near_z !== want.near_z) begin
					$error("near_z: expected %h, got %h", want.near_z, got.near_z);
					errors++;
				end
				if (got.fraction !== want.fraction) begin
					$error("fraction: expected %h, got %h", want.fraction, got.fraction);
					errors++;
				end
				if (got.region !== want.region) begin
					$error("region: expected %0d, got %0d", want.region, got.region);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_res.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		region_seen = '{0, 0, 0};
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all zero: no horizontal extent, start returned
		add_row(qry(0, 0, 0, 0, 0, 0, 0, 0), 1, rslt(0, 0, 0, 0, REG_INSIDE));
		// vertical segment: only y differs
		add_row(qry(ONE, 2*ONE, 5*ONE, 7*ONE, 9*ONE, 5*ONE, 100*ONE, 9*ONE), 1,
			rslt(5*ONE, 7*ONE, 9*ONE, 0, REG_INSIDE));
		// before the start, t = -0.5
		add_row(qry(-5*ONE, 0, 0, 3*ONE, 0, 10*ONE, -4*ONE, 0), 1,
			rslt(0, 3*ONE, 0, -ONE/2, REG_BEFORE));
		// past the end, t = 2
		add_row(qry(20*ONE, 0, 0, 3*ONE, 0, 10*ONE, -4*ONE, 0), 1,
			rslt(10*ONE, -4*ONE, 0, 2*ONE, REG_END));
		// exactly t = 1 counts as the end
		add_row(qry(10*ONE, 5*ONE, 0, 3*ONE, 0, 10*ONE, -4*ONE, 0), 1,
			rslt(10*ONE, -4*ONE, 0, ONE, REG_END));
		// exactly t = 0 stays interior
		add_row(qry(0, 5*ONE, 0, 3*ONE, 0, 10*ONE, -4*ONE, 0), 1,
			rslt(0, 3*ONE, 0, 0, REG_INSIDE));
		// midpoint, interpolation on all three axes
		add_row(qry(5*ONE, 0, 0, 3*ONE, 0, 10*ONE, -4*ONE, 0), 0, '0);
		// one-lsb segment, far query: fraction saturates both ways
		add_row(qry(FRAC_MAX, 0, 0, 0, 0, 1, 0, 0), 1, rslt(1, 0, 0, FRAC_MAX, REG_END));
		add_row(qry(FRAC_MIN, 0, 0, 0, 0, 1, 0, 0), 1, rslt(0, 0, 0, FRAC_MIN, REG_BEFORE));
		// small negative t rounds toward minus infinity
		add_row(qry(-1, 0, 0, 0, 0, 3, 0, 0), 0, '0);
		// widest segments and extreme points
		add_row(qry(FRAC_MAX, FRAC_MAX, FRAC_MIN, FRAC_MIN, FRAC_MIN,
			FRAC_MAX, FRAC_MAX, FRAC_MAX), 0, '0);
		add_row(qry(FRAC_MIN, FRAC_MIN, FRAC_MAX, FRAC_MAX, FRAC_MAX,
			FRAC_MIN, FRAC_MIN, FRAC_MIN), 0, '0);
		add_row(qry(0, 0, FRAC_MIN, FRAC_MAX, FRAC_MIN, FRAC_MAX, FRAC_MIN, FRAC_MAX), 0, '0);
		add_row(qry(-1, 0, FRAC_MAX, FRAC_MIN, FRAC_MAX, FRAC_MIN, FRAC_MAX, FRAC_MIN), 0, '0);
		// alternating bit patterns
		add_row(qry(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555), 0, '0);
		add_row(qry(32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA,
			32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA), 0, '0);
		// dot terms of opposite sign
		add_row(qry(3*ONE, -2*ONE, 0, 0, 0, 4*ONE, ONE, 4*ONE), 0, '0);
		add_row(qry(-3*ONE, 2*ONE, 0, 0, 0, 4*ONE, ONE, 4*ONE), 0, '0);
		// all ones, zero length
		add_row(qry(-1, -1, -1, -1, -1, -1, -1, -1), 1, rslt(-1, -1, -1, 0, REG_INSIDE));

		for (int i = 0; i < dir_query.size(); i++)
			send_query(dir_query[i], dir_known[i], dir_want[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % DRAIN_EVERY == 0)
				drain_results();
			send_query(random_query(), 0, '0);
		end

		s_tvalid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);

		$display("%0d items sent (%0d from the directed table), %0d results checked in %0d cycles",
			sent, dir_query.size(), checked, cycles);
		$display("regions seen: before %0d, end %0d, interior %0d; %0d mismatches",
			region_seen[0], region_seen[1], region_seen[2], errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
design/segcp_pkg.sv
design/segcp_front.sv
design/segcp_div.sv
design/segcp_back.sv
design/segcp_obuf.sv
design/segment_closest_point_xz_core.sv
tb/segment_closest_point_xz_core_test.sv
